>>> hw/rtl/itrc_pkg.sv
// Shared types, constants and helper functions of the IMU tilt and rate converter.
`timescale 1ns / 1ps
`default_nettype none

package itrc_pkg;

  // CORDIC datapath widths: x and y carry the axes scaled by 2^ACC_SHIFT, z is in 2^-16 degree.
  localparam int XW        = 27;
  localparam int ZW        = 27;
  localparam int ACC_SHIFT = 8;
  localparam int ATAN_DEPTH = 24;

  // Half a turn in 2^-16 degree.
  localparam logic signed [ZW-1:0] DEG180 = ZW'(180 * 65536);

  // atan(2^-i) in degrees times 65536, rounded.
  localparam logic [21:0] ATAN_TAB [ATAN_DEPTH] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117305,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
  };

  // Gyro full-scale codes, named after the sensitivity in LSB per deg/s.
  typedef enum logic [1:0] {
    RANGE_131  = 2'd0,
    RANGE_65P5 = 2'd1,
    RANGE_32P8 = 2'd2,
    RANGE_16P4 = 2'd3
  } gyro_range_t;

  // Ceiling reciprocals scaled by 2^32; exact floor division for the numerator widths used here.
  localparam int RECIP_SHIFT = 32;
  localparam int RW          = 27;
  localparam logic [RW-1:0] RECIP_262 = RW'(((64'd1 << 32) + 64'd261) / 64'd262);
  localparam logic [RW-1:0] RECIP_82  = RW'(((64'd1 << 32) + 64'd81) / 64'd82);
  localparam logic [RW-1:0] RECIP_34  = RW'(((64'd1 << 32) + 64'd33) / 64'd34);

  // Output limits.
  localparam logic signed [16:0] RATE_MAX = 17'sd32000;
  localparam logic signed [14:0] TEMP_MIN = -15'sd6000;
  localparam logic signed [14:0] TEMP_MAX = 15'sd13300;

  // One CORDIC lane.
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cordic_lane_t;

  // Rounding numerators and signs of the gyro and temperature divisions.
  typedef struct packed {
    logic [21:0]  gx_num;
    logic [21:0]  gy_num;
    logic [21:0]  gz_num;
    logic         gx_neg;
    logic         gy_neg;
    logic         gz_neg;
    logic [18:0]  t_num;
    logic         t_neg;
    gyro_range_t  range;
  } prep_side_t;

  // Signed quotients before saturation.
  typedef struct packed {
    logic signed [16:0] rate_x;
    logic signed [16:0] rate_y;
    logic signed [16:0] rate_z;
    logic signed [14:0] temp;
  } rate_side_t;

  // Everything that travels down the cell chain with one item.
  typedef struct packed {
    cordic_lane_t roll;
    cordic_lane_t pitch;
    rate_side_t   side;
  } stage_t;

  // Start of a vectoring CORDIC; a negative denominator is turned by half a turn first.
  function automatic cordic_lane_t cordic_init(logic signed [16:0] num, logic signed [15:0] den);
    cordic_lane_t r;
    r.x    = {{(XW-16-ACC_SHIFT){den[15]}}, den, {ACC_SHIFT{1'b0}}};
    r.y    = {{(XW-17-ACC_SHIFT){num[16]}}, num, {ACC_SHIFT{1'b0}}};
    r.z    = '0;
    r.zero = (num == 17'sd0) && (den == 16'sd0);
    if (den[15]) begin
      r.z = num[16] ? -DEG180 : DEG180;
      r.x = -r.x;
      r.y = -r.y;
    end
    return r;
  endfunction

  // One micro-rotation: clockwise while y is not negative.
  function automatic cordic_lane_t cordic_rot(cordic_lane_t a, int unsigned sh,
                                              logic signed [ZW-1:0] ang);
    cordic_lane_t r;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    dx = $signed(a.y) >>> sh;
    dy = $signed(a.x) >>> sh;
    r  = a;
    if (!a.y[XW-1]) begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + ang;
    end else begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - ang;
    end
    return r;
  endfunction

  // Magnitude of a raw 16-bit word; the most negative value maps to 32768.
  function automatic logic [15:0] mag16(logic [15:0] v);
    return v[15] ? (16'd0 - v) : v;
  endfunction

  // Reduced rounding numerator 2*160*|g|+s over 2*s, scaled down by the common factor.
  function automatic logic [21:0] gyro_num(logic [15:0] mag, gyro_range_t range);
    logic [21:0] m;
    logic [21:0] n;
    m = 22'(mag);
    unique case (range)
      RANGE_131:  n = (m << 5) + 22'd131;
      RANGE_65P5: n = (m << 6) + 22'd131;
      RANGE_32P8: n = (m << 5) + (m << 3) + 22'd41;
      RANGE_16P4: n = (m << 6) + (m << 4) + 22'd41;
      default:    n = '0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/itrc_rate_scale.sv
// Reciprocal multipliers that turn the rounding numerators into signed gyro rates and temperature.
`timescale 1ns / 1ps
`default_nettype none

module itrc_rate_scale
  import itrc_pkg::*;
(
  input  var prep_side_t prep,
  output var rate_side_t side
);

  logic [RW-1:0] recip;
  logic [48:0]   prod_x;
  logic [48:0]   prod_y;
  logic [48:0]   prod_z;
  logic [45:0]   prod_t;
  logic [16:0]   qx;
  logic [16:0]   qy;
  logic [16:0]   qz;
  logic [14:0]   qt;

  // Ranges 131 and 65.5 reduce to a divisor of 262, the two finer ranges to 82.
  always_comb begin
    unique case (prep.range)
      RANGE_131, RANGE_65P5: recip = RECIP_262;
      RANGE_32P8, RANGE_16P4: recip = RECIP_82;
      default:               recip = RECIP_262;
    endcase
  end

  // Floor quotients by multiplication with the ceiling reciprocal.
  assign prod_x = 49'(prep.gx_num) * 49'(recip);
  assign prod_y = 49'(prep.gy_num) * 49'(recip);
  assign prod_z = 49'(prep.gz_num) * 49'(recip);
  assign prod_t = 46'(prep.t_num) * 46'(RECIP_34);

  assign qx = {1'b0, prod_x[RECIP_SHIFT +: 16]};
  assign qy = {1'b0, prod_y[RECIP_SHIFT +: 16]};
  assign qz = {1'b0, prod_z[RECIP_SHIFT +: 16]};
  assign qt = {1'b0, prod_t[RECIP_SHIFT +: 14]};

  // Restore the sign; rounding was done on the magnitude, so halves go away from zero.
  assign side.rate_x = prep.gx_neg ? (17'sd0 - $signed(qx)) : $signed(qx);
  assign side.rate_y = prep.gy_neg ? (17'sd0 - $signed(qy)) : $signed(qy);
  assign side.rate_z = prep.gz_neg ? (17'sd0 - $signed(qz)) : $signed(qz);
  assign side.temp   = prep.t_neg  ? (15'sd0 - $signed(qt)) : $signed(qt);

endmodule

`default_nettype wire

>>> hw/rtl/itrc_cordic_cell.sv
// One CORDIC cell: a fixed micro-rotation of the roll and pitch lanes with its own valid stage.
`timescale 1ns / 1ps
`default_nettype none

module itrc_cordic_cell
  import itrc_pkg::*;
#(
  parameter int SHIFT = 0
)(
  input  var logic   clk,
  input  var logic   rst,
  input  var logic   in_valid,
  output var logic   in_ready,
  input  var stage_t in_data,
  output var logic   out_valid,
  input  var logic   out_ready,
  output var stage_t out_data
);

  localparam logic signed [ZW-1:0] ANGLE = ZW'(ATAN_TAB[SHIFT]);

  logic   valid;
  stage_t data;
  stage_t data_next;

  // The cell takes a new item when empty or when its item moves on in this cycle.
  assign in_ready = !valid || out_ready;

  // Rotate both lanes; the side results ride along untouched.
  always_comb begin
    data_next       = in_data;
    data_next.roll  = cordic_rot(in_data.roll, SHIFT, ANGLE);
    data_next.pitch = cordic_rot(in_data.pitch, SHIFT, ANGLE);
  end

  // Valid flag of the cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

`default_nettype wire

>>> hw/rtl/imu_tilt_rate_convert.sv
// Top level of the IMU tilt and rate converter: input stage, CORDIC cell chain and output register.
//
// Usage: the slave stream takes one raw inertial sample per item in s_axis_tdata
// (accel x/y/z, gyro x/y/z, raw temperature, 16 bits each, lowest first). The
// master stream returns one result item per sample: roll and pitch in
// 1/2^ANGLE_FRAC_BITS degree, three gyro rates in 1/16 deg/s and temperature in
// 1/100 degC. Results leave in the order the samples came in.
// The gyro range is set through cfg_wr_en/cfg_wr_data while no item is in flight.
// Stages: one input stage, one cell per CORDIC iteration, one output register.
// Throughput: one item per clock unless the receiver stalls. Every stage has
// its own valid bit and loads whenever it is empty or its item moves on, so
// bubbles close up.
// When the receiver stalls, the output register holds its item and the stages
// behind it fill; s_axis_tready falls only once every stage holds an item.
// Reset (rst, synchronous) empties all stages and sets the gyro range to 131 LSB
// per deg/s.
`timescale 1ns / 1ps
`default_nettype none

module imu_tilt_rate_convert
  import itrc_pkg::*;
#(
  parameter int CORDIC_STAGES   = 16,
  parameter int ANGLE_FRAC_BITS = 7
)(
  input  var logic         clk,
  input  var logic         rst,
  // Configuration: gyro_range.
  input  var logic         cfg_wr_en,
  input  var logic [1:0]   cfg_wr_data,
  // Input items.
  input  var logic         s_axis_tvalid,
  output var logic         s_axis_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, temp_raw
  input  var logic [111:0] s_axis_tdata,
  // Result items.
  output var logic         m_axis_tvalid,
  input  var logic         m_axis_tready,
  // roll_angle, pitch_angle, rate_x, rate_y, rate_z, temp_celsius, one zero pad bit
  output var logic [95:0]  m_axis_tdata
);

  localparam int ZW1     = ZW + 1;
  localparam int LIM_RAW = 180 * (2 ** ANGLE_FRAC_BITS);
  localparam int LIM_HI  = (LIM_RAW > 32767) ? 32767 : LIM_RAW;
  localparam int LIM_LO  = (LIM_RAW > 32768) ? -32768 : -LIM_RAW;
  localparam logic signed [ZW1-1:0] ANG_HI    = ZW1'(LIM_HI);
  localparam logic signed [ZW1-1:0] ANG_LO    = ZW1'(LIM_LO);
  localparam logic signed [ZW1-1:0] ANG_ROUND = ZW1'(2 ** (15 - ANGLE_FRAC_BITS));
  localparam int ANG_SHIFT = 16 - ANGLE_FRAC_BITS;

  gyro_range_t gyro_range;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_range <= RANGE_131;
    end else if (cfg_wr_en) begin
      gyro_range <= gyro_range_t'(cfg_wr_data);
    end
  end

  // Input field split.
  logic [15:0] accel_x;
  logic [15:0] accel_y;
  logic [15:0] accel_z;
  logic [15:0] gyro_x;
  logic [15:0] gyro_y;
  logic [15:0] gyro_z;
  logic [15:0] temp_raw;

  assign accel_x  = s_axis_tdata[15:0];
  assign accel_y  = s_axis_tdata[31:16];
  assign accel_z  = s_axis_tdata[47:32];
  assign gyro_x   = s_axis_tdata[63:48];
  assign gyro_y   = s_axis_tdata[79:64];
  assign gyro_z   = s_axis_tdata[95:80];
  assign temp_raw = s_axis_tdata[111:96];

  // Input stage: CORDIC start vectors and the rounding numerators of the divisions.
  logic signed [16:0] roll_num;
  logic signed [16:0] pitch_num;
  logic signed [18:0] temp_n;
  logic [18:0]        temp_mag;
  cordic_lane_t       roll_init;
  cordic_lane_t       pitch_init;
  prep_side_t         prep_next;

  assign roll_num  = $signed({accel_y[15], accel_y});
  assign pitch_num = 17'sd0 - $signed({accel_x[15], accel_x});
  assign temp_n    = $signed({{3{temp_raw[15]}}, temp_raw}) * 19'sd5 + 19'sd62101;
  assign temp_mag  = temp_n[18] ? (19'd0 - temp_n) : temp_n;

  always_comb begin
    roll_init        = cordic_init(roll_num, $signed(accel_z));
    pitch_init       = cordic_init(pitch_num, $signed(accel_z));
    prep_next.gx_num = gyro_num(mag16(gyro_x), gyro_range);
    prep_next.gy_num = gyro_num(mag16(gyro_y), gyro_range);
    prep_next.gz_num = gyro_num(mag16(gyro_z), gyro_range);
    prep_next.gx_neg = gyro_x[15];
    prep_next.gy_neg = gyro_y[15];
    prep_next.gz_neg = gyro_z[15];
    prep_next.t_num  = {temp_mag[17:0], 1'b0} + 19'd17;
    prep_next.t_neg  = temp_n[18];
    prep_next.range  = gyro_range;
  end

  logic         prep_valid;
  cordic_lane_t prep_roll;
  cordic_lane_t prep_pitch;
  prep_side_t   prep_side;

  // Chain links: link k feeds cell k; the last link feeds the output register.
  logic   link_valid [CORDIC_STAGES+1];
  logic   link_ready [CORDIC_STAGES+1];
  stage_t link_data  [CORDIC_STAGES+1];

  assign s_axis_tready = !prep_valid || link_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_valid <= 1'b0;
    end else if (s_axis_tready) begin
      prep_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      prep_roll  <= roll_init;
      prep_pitch <= pitch_init;
      prep_side  <= prep_next;
    end
  end

  // Gyro and temperature division on the way into the first cell.
  rate_side_t rate_side;

  itrc_rate_scale u_rate_scale (
    .prep (prep_side),
    .side (rate_side)
  );

  assign link_valid[0]      = prep_valid;
  assign link_data[0].roll  = prep_roll;
  assign link_data[0].pitch = prep_pitch;
  assign link_data[0].side  = rate_side;

  // CORDIC cell chain, one micro-rotation per cell.
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    itrc_cordic_cell #(
      .SHIFT (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (link_valid[k]),
      .in_ready  (link_ready[k]),
      .in_data   (link_data[k]),
      .out_valid (link_valid[k+1]),
      .out_ready (link_ready[k+1]),
      .out_data  (link_data[k+1])
    );
  end

  // Final rounding of the angles and saturation of all results.
  function automatic logic [15:0] angle_out(cordic_lane_t a);
    logic signed [ZW1-1:0] zr;
    logic signed [ZW1-1:0] r;
    zr = $signed({a.z[ZW-1], a.z}) + ANG_ROUND;
    r  = zr >>> ANG_SHIFT;
    if (r > ANG_HI) begin
      r = ANG_HI;
    end else if (r < ANG_LO) begin
      r = ANG_LO;
    end
    if (a.zero) begin
      r = '0;
    end
    return r[15:0];
  endfunction

  function automatic logic [15:0] rate_out(logic signed [16:0] v);
    logic signed [16:0] r;
    r = v;
    if (v > RATE_MAX) begin
      r = RATE_MAX;
    end else if (v < -RATE_MAX) begin
      r = -RATE_MAX;
    end
    return r[15:0];
  endfunction

  stage_t       last;
  logic [14:0]  temp_sat;
  logic [95:0]  out_next;

  assign last = link_data[CORDIC_STAGES];

  always_comb begin
    priority if (last.side.temp > TEMP_MAX) begin
      temp_sat = TEMP_MAX;
    end else if (last.side.temp < TEMP_MIN) begin
      temp_sat = TEMP_MIN;
    end else begin
      temp_sat = last.side.temp;
    end
    out_next = {1'b0, temp_sat, rate_out(last.side.rate_z), rate_out(last.side.rate_y),
                rate_out(last.side.rate_x), angle_out(last.pitch), angle_out(last.roll)};
  end

  // Output register; it holds its item while the receiver stalls.
  assign link_ready[CORDIC_STAGES] = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (link_ready[CORDIC_STAGES]) begin
      m_axis_tvalid <= link_valid[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (link_ready[CORDIC_STAGES] && link_valid[CORDIC_STAGES]) begin
      m_axis_tdata <= out_next;
    end
  end

endmodule

`default_nettype wire

>>> sim/imu_result_checker.sv
// Checker that predicts every result item of the tilt and rate converter and compares it.
`timescale 1ns / 1ps

module imu_result_checker
  import itrc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_wr_data,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, temp_raw
  input  logic [111:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // roll_angle, pitch_angle, rate_x, rate_y, rate_z, temp_celsius, zero pad bit
  input  logic [95:0]  m_axis_tdata,
  output int           mismatches,
  output int           in_flight
);

  localparam int     STAGES    = 16;
  localparam int     FRAC      = 7;
  localparam longint ANGLE_LIM = 180 * (1 << FRAC);
  localparam longint HALF_TURN = 180 * 65536;

  // One converted sample, field by field.
  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [14:0] temp;
  } tilt_rate_t;

  tilt_rate_t  expected_outputs[$];
  gyro_range_t range_now = RANGE_131;
  int          fail_tally = 0;

  assign mismatches = fail_tally;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Division rounded to nearest with halves away from zero; the divisor is positive.
  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (2 * n + d) / (2 * d);
    return -((2 * (-n) + d) / (2 * d));
  endfunction

  // Vectoring CORDIC for atan2(num, den), result in 1/2^FRAC degree.
  function automatic logic signed [15:0] tilt_angle(longint num, longint den);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint r;
    if (num == 0 && den == 0) return '0;
    x = den * 256;
    y = num * 256;
    z = 0;
    // A negative denominator is turned by half a turn before the iterations.
    if (x < 0) begin
      z = (y >= 0) ? HALF_TURN : -HALF_TURN;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_TAB[i]);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_TAB[i]);
      end
    end
    r = (z + (longint'(1) << (15 - FRAC))) >>> (16 - FRAC);
    return 16'(clamp(r, -ANGLE_LIM, ANGLE_LIM));
  endfunction

  // Raw gyro word to 1/16 deg/s for the selected full scale.
  function automatic logic signed [15:0] gyro_rate(logic signed [15:0] raw, gyro_range_t range);
    longint sens_x10;
    case (range)
      RANGE_131:  sens_x10 = 1310;
      RANGE_65P5: sens_x10 = 655;
      RANGE_32P8: sens_x10 = 328;
      default:    sens_x10 = 164;
    endcase
    return 16'(clamp(round_div(longint'(raw) * 160, sens_x10), -32000, 32000));
  endfunction

  function automatic tilt_rate_t predict_outputs(logic [111:0] d, gyro_range_t range);
    tilt_rate_t res;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] t;
    ax = d[15:0];
    ay = d[31:16];
    az = d[47:32];
    t  = d[111:96];
    res.roll   = tilt_angle(longint'(ay), longint'(az));
    res.pitch  = tilt_angle(-longint'(ax), longint'(az));
    res.rate_x = gyro_rate(d[63:48], range);
    res.rate_y = gyro_rate(d[79:64], range);
    res.rate_z = gyro_rate(d[95:80], range);
    res.temp   = 15'(clamp(round_div(longint'(t) * 5 + 3653 * 17, 17), -6000, 13300));
    return res;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      fail_tally++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Track the range register, predict on each accepted sample, compare each result item.
  always @(posedge clk) begin : watch
    tilt_rate_t got;
    tilt_rate_t want;
    if (rst) begin
      expected_outputs.delete();
      range_now = RANGE_131;
    end else begin
      if (cfg_wr_en) range_now = gyro_range_t'(cfg_wr_data);
      if (s_axis_tvalid && s_axis_tready)
        expected_outputs.push_back(predict_outputs(s_axis_tdata, range_now));
      if (m_axis_tvalid && m_axis_tready) begin
        got.roll   = m_axis_tdata[15:0];
        got.pitch  = m_axis_tdata[31:16];
        got.rate_x = m_axis_tdata[47:32];
        got.rate_y = m_axis_tdata[63:48];
        got.rate_z = m_axis_tdata[79:64];
        got.temp   = m_axis_tdata[94:80];
        if (expected_outputs.size() == 0) begin
          fail_tally++;
          $display("%0t: result item with no sample waiting, expected none, actual %h",
                   $time, m_axis_tdata);
        end else begin
          want = expected_outputs.pop_front();
          check_field("roll_angle", want.roll, got.roll);
          check_field("pitch_angle", want.pitch, got.pitch);
          check_field("rate_x", want.rate_x, got.rate_x);
          check_field("rate_y", want.rate_y, got.rate_y);
          check_field("rate_z", want.rate_z, got.rate_z);
          check_field("temp_celsius", want.temp, got.temp);
        end
      end
    end
    in_flight <= expected_outputs.size();
  end

endmodule

>>> sim/testbench.sv
// Top of the converter testbench: clock, reset, sample stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module testbench;
  import itrc_pkg::*;

  localparam int PIPE_LATENCY    = 18;
  localparam int ITEMS_PER_PHASE = 180;
  localparam int DRAIN_LIMIT     = 20000;
  localparam logic [15:0] LIMIT_WORDS [6] = '{
    16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF
  };

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_wr_en = 1'b0;
  logic [1:0]   cfg_wr_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  int           mismatches;
  int           in_flight;
  bit           steady = 1'b0;
  int           stall_left = 0;

  always #10 clk = ~clk;

  imu_tilt_rate_convert i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  imu_result_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .in_flight     (in_flight)
  );

  // Idle length: mostly none or short, now and then long enough to back up the pipeline.
  function automatic int idle_length(bit no_gaps);
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Raw word biased toward the ends of the range and small values.
  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return LIMIT_WORDS[$urandom_range(0, 5)];
      1:       return 16'($urandom_range(0, 511) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one sample, wait for it to be taken, then idle for a while.
  task automatic send_sample(input logic [15:0] ax, ay, az, gx, gy, gz, t);
    int gap;
    s_axis_tdata  <= {t, gz, gy, gx, az, ay, ax};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    gap = idle_length(steady);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
  endtask

  // Receiver: random stalls of varied length, none while in steady mode.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left    <= idle_length(steady);
    end
  end

  initial begin : stimulus
    gyro_range_t plan [6];
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] az;
    int          kind;
    int          waited;
    plan = '{RANGE_131, RANGE_16P4, RANGE_65P5, RANGE_32P8, RANGE_16P4, RANGE_131};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed samples under the reset range: zero operands, half-turn cases, extremes.
    send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h0000, 16'hC000, 16'h0001, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_sample(16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0001);
    send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_sample(16'h0000, 16'h4000, 16'h0000, 16'h0041, 16'hFFBF, 16'h0083, 16'h0154);
    send_sample(16'h0000, 16'hC000, 16'h0000, 16'h8001, 16'h7FFE, 16'h0002, 16'hFEAC);
    send_sample(16'h4000, 16'hFFFF, 16'hC000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'hFFFF, 16'h0001, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h0001, 16'hFFFF, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF);
    send_sample(16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h8000);
    send_sample(16'h0001, 16'h0001, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h2D41, 16'hD2BF, 16'h2D41, 16'h1234, 16'hEDCC, 16'h0ABC, 16'h0D4C);

    // Random phases, one per entry of the range plan; one phase runs with no idling at all.
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      steady = (p == 3);
      cfg_wr_data <= plan[p];
      cfg_wr_en   <= 1'b1;
      @(posedge clk);
      cfg_wr_en   <= 1'b0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
          // Plausible tilt: gravity spread over the three axes.
          ax = 16'($urandom_range(0, 34000) - 17000);
          ay = 16'($urandom_range(0, 34000) - 17000);
          az = 16'($urandom_range(0, 34000) - 17000);
        end else if (kind < 8) begin
          ax = rand_word();
          ay = rand_word();
          az = rand_word();
        end else if (kind == 8) begin
          // Zero numerator or zero denominator with random partners.
          ax = ($urandom_range(0, 1) != 0) ? 16'h0000 : rand_word();
          ay = ($urandom_range(0, 1) != 0) ? 16'h0000 : rand_word();
          az = ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'($urandom | 32'h8000);
        end else begin
          ax = 16'($urandom);
          ay = 16'($urandom);
          az = 16'($urandom);
        end
        send_sample(ax, ay, az, rand_word(), rand_word(), rand_word(), rand_word());
      end
    end

    // Let the pipeline empty, then allow for stray results.
    s_axis_tvalid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (in_flight != 0 && waited < DRAIN_LIMIT);
    repeat (PIPE_LATENCY + 4) @(posedge clk);

    if (mismatches == 0 && in_flight == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
